// File: rtl/sbct_pkg.sv
// Shared types and constants for the sensorless BLDC commutation timing block.
// Holds the event and result records, command, stage, phase and register codes.
// No dependencies.
package sbct_pkg;

   // Fixed widths of the port fields.
   localparam int PORT_TIME_W   = 24;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 24;
   localparam int TIME_BITS_DEF = 24;

   // Event commands.
   localparam logic [1:0] CMD_ZERO_CROSS = 2'd0;
   localparam logic [1:0] CMD_TIMER      = 2'd1;
   localparam logic [1:0] CMD_WATCHDOG   = 2'd2;
   localparam logic [1:0] CMD_UNUSED     = 2'd3;

   // Startup stages.
   localparam logic [1:0] ST_FIRST   = 2'd0;
   localparam logic [1:0] ST_MEASURE = 2'd1;
   localparam logic [1:0] ST_CLOSED  = 2'd2;

   // BEMF sub-states.
   localparam logic [1:0] PH_COMMUTATE = 2'd0;
   localparam logic [1:0] PH_WAITING   = 2'd1;
   localparam logic [1:0] PH_DETECTED  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_STARTUP_STEPS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_COMM_AVG = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PWM_ON_INIT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PWM_ON_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISCHARGE_LIM = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_PERIOD   = 3'd5;

   // Register defaults after reset.
   localparam logic [7:0]  STARTUP_STEPS_RST = 8'd6;
   localparam int          INIT_COMM_AVG_RST = 5000;
   localparam logic [7:0]  PWM_ON_INIT_RST   = 8'd50;
   localparam logic [7:0]  PWM_ON_LIMIT_RST  = 8'd88;
   localparam logic [7:0]  DISCHARGE_LIM_RST = 8'd40;
   localparam logic [7:0]  RAMP_PERIOD_RST   = 8'd10;

   // Fixed timings in microseconds.
   localparam int FIRST_STEP_DELAY_US = 20000;
   localparam int COMM_LEAD_US        = 20;
   localparam int MEASURE_LEAD_US     = 11;
   localparam int MEASURE_BLANK_US    = 200;

   typedef struct packed {
      logic [1:0]             cmd;
      logic                   slope_positive;
      logic [PORT_TIME_W-1:0] comm_timer_us;
      logic [PORT_TIME_W-1:0] zcd_timer_us;
   } sbct_item_type;

   typedef struct packed {
      logic                   timer_load;
      logic [PORT_TIME_W-1:0] timer_delay_us;
      logic [1:0]             advance_steps;
      logic                   freewheel;
      logic                   blanking_start;
      logic [PORT_TIME_W-1:0] blanking_us;
      logic [7:0]             pwm_on_us;
      logic [1:0]             stage;
      logic                   zcd_lost;
      logic                   stopped;
   } sbct_result_type;

endpackage

// File: rtl/sbct_engine.sv
// Commutation timing state, configuration registers and the single-pass
// event update. Depends on sbct_pkg.
module sbct_engine
   import sbct_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  sbct_item_type          item,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output sbct_result_type        result
);

   localparam int TW = TIME_BITS;
   localparam int CW = (TW > PORT_TIME_W) ? TW : PORT_TIME_W;
   localparam logic [TW-1:0] TMAX = '1;

   function automatic logic [TW-1:0] sub0(input logic [TW-1:0] a, input logic [TW-1:0] b);
      sub0 = (a > b) ? a - b : '0;
   endfunction

   function automatic logic [TW-1:0] in_time(input logic [PORT_TIME_W-1:0] v);
      logic [CW-1:0] w;
      w = CW'(v);
      if (w > CW'(TMAX)) w = CW'(TMAX);
      in_time = w[TW-1:0];
   endfunction

   function automatic logic [PORT_TIME_W-1:0] out_time(input logic [TW-1:0] v);
      logic [CW-1:0] w;
      w = CW'(v);
      out_time = w[PORT_TIME_W-1:0];
   endfunction

   // Configuration registers that are read by the update logic.
   logic [7:0] pwm_limit_ff, dis_limit_ff, ramp_period_ff;

   // Motor state.
   logic [1:0]    stage_ff, stage_in;
   logic [1:0]    phase_ff, phase_in;
   logic [7:0]    steps_ff, steps_in;
   logic [TW-1:0] ctime_ff, ctime_in;
   logic [TW-1:0] cavg_ff, cavg_in;
   logic [TW-1:0] zp_ff, zp_in;
   logic [TW-1:0] zpa_ff, zpa_in;
   logic [TW-1:0] c2z_ff, c2z_in;
   logic [TW-1:0] c2za_ff, c2za_in;
   logic [7:0]    dis_ff, dis_in;
   logic [7:0]    adis_ff, adis_in;
   logic          pend_ff, pend_in;
   logic [7:0]    ramp_ff, ramp_in;
   logic [7:0]    pwm_ff, pwm_in;
   logic          halt_ff, halt_in;

   always_comb begin
      logic [TW-1:0]   tcomm, tzcd;
      logic            rising, do_commute, do_split;
      logic [TW-1:0]   split_t, delay, blank_us;
      logic [7:0]      split_ad;
      logic            load, fw, blank, lost;
      logic [1:0]      adv;
      logic [TW+2:0]   avg_sum;
      logic [TW:0]     zsum, csum;
      logic [TW-1:0]   expect_t;
      logic [TW+2:0]   err;
      logic [TW:0]     terr;
      logic [TW+1:0]   nxt;

      tcomm      = in_time(item.comm_timer_us);
      tzcd       = in_time(item.zcd_timer_us);
      rising     = !item.slope_positive;
      do_commute = 1'b0;
      do_split   = 1'b0;
      split_t    = '0;
      split_ad   = adis_ff;
      delay      = '0;
      blank_us   = '0;
      load       = 1'b0;
      fw         = 1'b0;
      blank      = 1'b0;
      lost       = 1'b0;
      adv        = 2'd0;
      avg_sum    = '0;
      zsum       = '0;
      csum       = '0;
      expect_t   = '0;
      err        = '0;
      terr       = '0;
      nxt        = '0;

      stage_in = stage_ff;
      phase_in = phase_ff;
      steps_in = steps_ff;
      ctime_in = ctime_ff;
      cavg_in  = cavg_ff;
      zp_in    = zp_ff;
      zpa_in   = zpa_ff;
      c2z_in   = c2z_ff;
      c2za_in  = c2za_ff;
      dis_in   = dis_ff;
      adis_in  = adis_ff;
      pend_in  = pend_ff;
      ramp_in  = ramp_ff;
      pwm_in   = pwm_ff;
      halt_in  = halt_ff;

      if (halt_ff) begin
         fw = 1'b1;
      end else begin
         unique case (item.cmd)
            CMD_ZERO_CROSS: begin
               if (stage_ff == ST_FIRST) begin
                  phase_in = PH_DETECTED;
                  if (item.slope_positive) c2z_in = tcomm;
                  if (steps_ff != 8'd0) begin
                     if (!item.slope_positive) steps_in = steps_ff - 8'd1;
                     do_commute = 1'b1;
                  end else begin
                     adv      = 2'd2;
                     fw       = 1'b1;
                     stage_in = ST_MEASURE;
                     blank    = 1'b1;
                     blank_us = TW'(MEASURE_BLANK_US);
                  end
               end else if (stage_ff == ST_MEASURE) begin
                  if (steps_ff == 8'd0) begin
                     // One long timer period while the rotor freewheels.
                     do_split = 1'b1;
                     split_t  = (cavg_ff[TW-1 -: 4] != 4'd0) ? TMAX : {cavg_ff[TW-5:0], 4'b0};
                     steps_in = 8'd1;
                     adv      = 2'd2;
                     fw       = 1'b1;
                     blank    = 1'b1;
                     blank_us = cavg_ff >> 1;
                  end else begin
                     zp_in    = tcomm;
                     zpa_in   = tcomm;
                     cavg_in  = tcomm >> 1;
                     do_split = 1'b1;
                     split_t  = sub0(tcomm >> 2, TW'(MEASURE_LEAD_US));
                     ctime_in = tcomm >> 1;
                     c2z_in   = tcomm >> 2;
                     c2za_in  = tcomm >> 2;
                     stage_in = ST_CLOSED;
                     phase_in = PH_DETECTED;
                  end
               end else begin
                  c2z_in   = tcomm;
                  zp_in    = tzcd;
                  phase_in = PH_DETECTED;
               end
            end
            CMD_TIMER: begin
               if (pend_ff) begin
                  fw      = 1'b1;
                  pend_in = 1'b0;
                  load    = 1'b1;
                  delay   = TW'(adis_ff);
               end else begin
                  do_commute = 1'b1;
               end
            end
            CMD_WATCHDOG: begin
               halt_in = 1'b1;
               fw      = 1'b1;
            end
            CMD_UNUSED: begin
            end
         endcase
      end

      if (do_commute) begin
         if (stage_ff == ST_FIRST) begin
            adv = 2'd1;
            if (rising) begin
               avg_sum  = (TW+3)'({cavg_ff, 2'b00}) + (TW+3)'({cavg_ff, 1'b0})
                        + (TW+3)'(tcomm);
               cavg_in  = avg_sum[TW+2:3];
               ctime_in = tcomm >> 1;
               load     = 1'b1;
               delay    = TW'(FIRST_STEP_DELAY_US);
            end
            blank    = 1'b1;
            blank_us = cavg_in >> 3;
         end else if (stage_ff == ST_CLOSED) begin
            adv = 2'd1;
            if (rising) begin
               if (phase_ff != PH_COMMUTATE) begin
                  // Rising step without a finished crossing cycle: sequencing error.
                  fw      = 1'b1;
                  halt_in = 1'b1;
               end else begin
                  phase_in = PH_WAITING;
                  adis_in  = 8'd0;
                  do_split = 1'b1;
                  split_ad = 8'd0;
                  split_t  = sub0(ctime_ff, TW'(COMM_LEAD_US));
                  blank    = 1'b1;
                  blank_us = (cavg_ff >> 3) + (cavg_ff >> 6);
               end
            end else if (phase_ff != PH_DETECTED) begin
               // The crossing was missed: fall back to freewheel measurement.
               if (pwm_ff >= pwm_limit_ff && dis_ff < dis_limit_ff) dis_in = dis_ff + 8'd1;
               adv      = 2'd2;
               fw       = 1'b1;
               lost     = 1'b1;
               stage_in = ST_MEASURE;
               steps_in = 8'd0;
               blank    = 1'b1;
               blank_us = cavg_ff >> 1;
            end else begin
               phase_in = PH_COMMUTATE;
               zsum     = {1'b0, zpa_ff} + {1'b0, zp_ff};
               csum     = {1'b0, c2za_ff} + {1'b0, c2z_ff};
               zpa_in   = zsum[TW:1];
               c2za_in  = csum[TW:1];
               expect_t = (zpa_in >> 2) + (zpa_in >> 4);
               err      = $signed({3'b000, zpa_in >> 1}) - $signed({3'b000, ctime_ff})
                        + $signed({3'b000, c2za_in}) - $signed({3'b000, expect_t});
               if (err[TW+2:TW] == 3'b000 || err[TW+2:TW] == 3'b111) begin
                  terr = err[TW:0];
               end else if (err[TW+2]) begin
                  terr = {1'b1, {TW{1'b0}}};
               end else begin
                  terr = {1'b0, TMAX};
               end
               ctime_in = zpa_in >> 1;
               adis_in  = dis_ff;
               nxt      = $signed({2'b00, ctime_in}) + $signed({terr[TW], terr});
               do_split = 1'b1;
               split_ad = dis_ff;
               if (nxt[TW+1]) begin
                  split_t = '0;
               end else if (nxt[TW]) begin
                  split_t = TMAX;
               end else begin
                  split_t = nxt[TW-1:0];
               end
               if (ramp_ff < ramp_period_ff) begin
                  ramp_in = ramp_ff + 8'd1;
               end else if (pwm_ff < pwm_limit_ff) begin
                  ramp_in = 8'd0;
                  pwm_in  = pwm_ff + 8'd1;
               end
            end
         end
      end

      // A timer load is shortened by the discharge time, which then follows
      // as a separate freewheel period.
      if (do_split) begin
         load = 1'b1;
         if (split_ad == 8'd0) begin
            pend_in = 1'b0;
            delay   = split_t;
         end else begin
            pend_in = 1'b1;
            delay   = sub0(split_t, TW'(split_ad));
         end
      end

      result.timer_load     = load;
      result.timer_delay_us = out_time(delay);
      result.advance_steps  = adv;
      result.freewheel      = fw;
      result.blanking_start = blank;
      result.blanking_us    = out_time(blank_us);
      result.pwm_on_us      = pwm_in;
      result.stage          = stage_in;
      result.zcd_lost       = lost;
      result.stopped        = halt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_limit_ff   <= PWM_ON_LIMIT_RST;
         dis_limit_ff   <= DISCHARGE_LIM_RST;
         ramp_period_ff <= RAMP_PERIOD_RST;
         stage_ff       <= ST_FIRST;
         phase_ff       <= PH_COMMUTATE;
         steps_ff       <= STARTUP_STEPS_RST;
         ctime_ff       <= '0;
         cavg_ff        <= in_time(PORT_TIME_W'(INIT_COMM_AVG_RST));
         zp_ff          <= '0;
         zpa_ff         <= '0;
         c2z_ff         <= '0;
         c2za_ff        <= '0;
         dis_ff         <= '0;
         adis_ff        <= '0;
         pend_ff        <= 1'b0;
         ramp_ff        <= '0;
         pwm_ff         <= PWM_ON_INIT_RST;
         halt_ff        <= 1'b0;
      end else begin
         if (step) begin
            stage_ff <= stage_in;
            phase_ff <= phase_in;
            steps_ff <= steps_in;
            ctime_ff <= ctime_in;
            cavg_ff  <= cavg_in;
            zp_ff    <= zp_in;
            zpa_ff   <= zpa_in;
            c2z_ff   <= c2z_in;
            c2za_ff  <= c2za_in;
            dis_ff   <= dis_in;
            adis_ff  <= adis_in;
            pend_ff  <= pend_in;
            ramp_ff  <= ramp_in;
            pwm_ff   <= pwm_in;
            halt_ff  <= halt_in;
         end
         // Writes of the first three registers load the state they seed.
         if (csr_we) begin
            unique case (csr_index)
               CSR_STARTUP_STEPS: steps_ff       <= csr_wdata[7:0];
               CSR_INIT_COMM_AVG: cavg_ff        <= in_time(csr_wdata);
               CSR_PWM_ON_INIT:   pwm_ff         <= csr_wdata[7:0];
               CSR_PWM_ON_LIMIT:  pwm_limit_ff   <= csr_wdata[7:0];
               CSR_DISCHARGE_LIM: dis_limit_ff   <= csr_wdata[7:0];
               CSR_RAMP_PERIOD:   ramp_period_ff <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
   end

endmodule

// File: rtl/sensorless_bldc_commutation_timing.sv
// Each event is loaded into the event register at its transfer and moves to the result
// register when that is free or draining. Throughput: one event per cycle while results
// are taken; the event register refills while a result waits.
// Reset clears the startup state, the averaged timings and the configuration
// registers to their defaults.
// Top level of the sensorless BLDC commutation timing block.
// Depends on sbct_pkg and sbct_engine.
module sensorless_bldc_commutation_timing
   import sbct_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_cmd,
   input  logic                   req_slope_positive,
   input  logic [PORT_TIME_W-1:0] req_comm_timer_us,
   input  logic [PORT_TIME_W-1:0] req_zcd_timer_us,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_timer_load,
   output logic [PORT_TIME_W-1:0] rsp_timer_delay_us,
   output logic [1:0]             rsp_advance_steps,
   output logic                   rsp_freewheel,
   output logic                   rsp_blanking_start,
   output logic [PORT_TIME_W-1:0] rsp_blanking_us,
   output logic [7:0]             rsp_pwm_on_us,
   output logic [1:0]             rsp_stage,
   output logic                   rsp_zcd_lost,
   output logic                   rsp_stopped,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic            in_valid_ff;
   sbct_item_type   item_ff;
   logic            out_valid_ff;
   sbct_result_type result_ff;
   sbct_result_type result;
   logic            advance;

   // The held event moves on when the result register is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   sbct_engine #(
      .TIME_BITS (TIME_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (item_ff),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.cmd            <= req_cmd;
         item_ff.slope_positive <= req_slope_positive;
         item_ff.comm_timer_us  <= req_comm_timer_us;
         item_ff.zcd_timer_us   <= req_zcd_timer_us;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_timer_load     = result_ff.timer_load;
   assign rsp_timer_delay_us = result_ff.timer_delay_us;
   assign rsp_advance_steps  = result_ff.advance_steps;
   assign rsp_freewheel      = result_ff.freewheel;
   assign rsp_blanking_start = result_ff.blanking_start;
   assign rsp_blanking_us    = result_ff.blanking_us;
   assign rsp_pwm_on_us      = result_ff.pwm_on_us;
   assign rsp_stage          = result_ff.stage;
   assign rsp_zcd_lost       = result_ff.zcd_lost;
   assign rsp_stopped        = result_ff.stopped;

endmodule

// File: rtl/sbct_checker.sv
// Port-level assertions for the commutation timing block, with the bind
// that attaches them to the top level. Depends on sbct_pkg.
module sbct_checker
   import sbct_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_timer_load,
   input logic [PORT_TIME_W-1:0] rsp_timer_delay_us,
   input logic [1:0]             rsp_advance_steps,
   input logic                   rsp_freewheel,
   input logic                   rsp_blanking_start,
   input logic [PORT_TIME_W-1:0] rsp_blanking_us,
   input logic [1:0]             rsp_stage,
   input logic                   rsp_zcd_lost,
   input logic                   rsp_stopped
);

   // Set once a stopped result has been transferred; only reset restarts the motor.
   logic stop_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_stopped) begin
         stop_seen_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before its transfer");

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && stop_seen_ff |-> rsp_stopped && rsp_freewheel && !rsp_timer_load
         && rsp_advance_steps == 2'd0 && !rsp_blanking_start)
      else $error("orders given after the motor stopped");

   a_zero_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_timer_load || rsp_timer_delay_us == '0)
         && (rsp_blanking_start || rsp_blanking_us == '0))
      else $error("time given without its order");

   a_lost_fallback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zcd_lost |-> rsp_stage == ST_MEASURE && rsp_advance_steps == 2'd2
         && rsp_freewheel)
      else $error("lost crossing without fallback to measurement");

endmodule

bind sensorless_bldc_commutation_timing sbct_checker u_sbct_checker (.*);

// File: dv/tb.sv
// Self-checking testbench for sensorless_bldc_commutation_timing.
// A predictor class tracks the startup stage, averaged timings and register settings.
// Depends on sbct_pkg and the RTL of the block only.
module tb;
   import sbct_pkg::*;

   localparam longint unsigned TIME_MAX = (longint'(1) << TIME_BITS_DEF) - 1;
   localparam int STALL_LIMIT = 2000;

   // Expected commutation orders for every accepted event, checked in order of arrival.
   class commutation_tracker;
      bit [7:0]             cfg_startup_steps, cfg_pwm_init, cfg_pwm_limit;
      bit [7:0]             cfg_discharge_limit, cfg_ramp_period;
      bit [PORT_TIME_W-1:0] cfg_init_comm;
      bit [1:0]             run_stage, bemf_state;
      bit [7:0]             open_steps_left, discharge_us, split_us, ramp_cnt, pwm_on;
      bit [PORT_TIME_W-1:0] comm_half, comm_mean, zc_period, zc_period_mean;
      bit [PORT_TIME_W-1:0] comm_to_zc, comm_to_zc_mean;
      bit                   split_pending, motor_halted;
      sbct_result_type      order;
      sbct_result_type      orders_due[$];
      int                   mismatches;

      function new();
         cfg_startup_steps   = STARTUP_STEPS_RST;
         cfg_init_comm       = PORT_TIME_W'(INIT_COMM_AVG_RST);
         cfg_pwm_init        = PWM_ON_INIT_RST;
         cfg_pwm_limit       = PWM_ON_LIMIT_RST;
         cfg_discharge_limit = DISCHARGE_LIM_RST;
         cfg_ramp_period     = RAMP_PERIOD_RST;
         run_stage           = ST_FIRST;
         bemf_state          = PH_COMMUTATE;
         open_steps_left     = cfg_startup_steps;
         comm_mean           = cfg_init_comm;
         pwm_on              = cfg_pwm_init;
         mismatches          = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_STARTUP_STEPS: begin
               cfg_startup_steps = val[7:0];
               open_steps_left   = val[7:0];
            end
            CSR_INIT_COMM_AVG: begin
               cfg_init_comm = val;
               comm_mean     = val;
            end
            CSR_PWM_ON_INIT: begin
               cfg_pwm_init = val[7:0];
               pwm_on       = val[7:0];
            end
            CSR_PWM_ON_LIMIT:  cfg_pwm_limit = val[7:0];
            CSR_DISCHARGE_LIM: cfg_discharge_limit = val[7:0];
            CSR_RAMP_PERIOD:   cfg_ramp_period = val[7:0];
            default: ;
         endcase
      endfunction

      function bit [PORT_TIME_W-1:0] clip(longint unsigned v);
         return (v > TIME_MAX) ? PORT_TIME_W'(TIME_MAX) : PORT_TIME_W'(v);
      endfunction

      function longint unsigned floor_sub(longint unsigned a, longint unsigned b);
         return (a > b) ? a - b : 0;
      endfunction

      function void load_now(longint unsigned t);
         order.timer_load     = 1'b1;
         order.timer_delay_us = clip(t);
      endfunction

      // A nonzero discharge time shortens the load; the next expiry reloads the rest.
      function void load_with_split(longint unsigned t);
         bit [PORT_TIME_W-1:0] c;
         c = clip(t);
         if (split_us == 0) begin
            split_pending = 1'b0;
            load_now(c);
         end else begin
            split_pending = 1'b1;
            load_now(floor_sub(c, split_us));
         end
      endfunction

      function void blank_for(longint unsigned t);
         order.blanking_start = 1'b1;
         order.blanking_us    = clip(t);
      endfunction

      function void close_timing_loop();
         longint unsigned sum;
         longint          half, lag, held, lead, err, next_delay;
         sum = zc_period_mean;
         sum += zc_period;
         zc_period_mean = PORT_TIME_W'(sum >> 1);
         sum = comm_to_zc_mean;
         sum += comm_to_zc;
         comm_to_zc_mean = PORT_TIME_W'(sum >> 1);
         half = zc_period_mean >> 1;
         lag  = (zc_period_mean >> 2) + (zc_period_mean >> 4);
         held = comm_half;
         lead = comm_to_zc_mean;
         err  = half - held + (lead - lag);
         if (err > longint'(TIME_MAX)) err = longint'(TIME_MAX);
         if (err < -longint'(TIME_MAX) - 1) err = -longint'(TIME_MAX) - 1;
         comm_half  = PORT_TIME_W'(half);
         split_us   = discharge_us;
         next_delay = half + err;
         if (next_delay < 0) next_delay = 0;
         load_with_split(longint'(next_delay));
         if (ramp_cnt < cfg_ramp_period) begin
            ramp_cnt++;
         end else if (pwm_on < cfg_pwm_limit) begin
            ramp_cnt = 8'd0;
            pwm_on++;
         end
      endfunction

      function void commutate(bit slope_pos, bit [PORT_TIME_W-1:0] tc);
         longint unsigned mix;
         if (run_stage == ST_FIRST) begin
            order.advance_steps = 2'd1;
            if (!slope_pos) begin
               mix = comm_mean;
               mix = (mix * 6 + tc) >> 3;
               comm_mean = PORT_TIME_W'(mix);
               comm_half = tc >> 1;
               load_now(FIRST_STEP_DELAY_US);
            end
            blank_for(comm_mean >> 3);
         end else if (run_stage == ST_CLOSED) begin
            order.advance_steps = 2'd1;
            if (!slope_pos) begin
               // A rising step while the last cycle is unfinished means the sequence slipped.
               if (bemf_state != PH_COMMUTATE) begin
                  order.freewheel = 1'b1;
                  motor_halted    = 1'b1;
               end else begin
                  bemf_state = PH_WAITING;
                  split_us   = 8'd0;
                  load_with_split(floor_sub(comm_half, COMM_LEAD_US));
                  blank_for((comm_mean >> 3) + (comm_mean >> 6));
               end
            end else if (bemf_state != PH_DETECTED) begin
               if (pwm_on >= cfg_pwm_limit && discharge_us < cfg_discharge_limit)
                  discharge_us++;
               order.advance_steps = 2'd2;
               order.freewheel     = 1'b1;
               order.zcd_lost      = 1'b1;
               run_stage           = ST_MEASURE;
               open_steps_left     = 8'd0;
               blank_for(comm_mean >> 1);
            end else begin
               bemf_state = PH_COMMUTATE;
               close_timing_loop();
            end
         end
      endfunction

      function void take_crossing(bit slope_pos, bit [PORT_TIME_W-1:0] tc,
                                  bit [PORT_TIME_W-1:0] tz);
         longint unsigned wide;
         if (run_stage == ST_FIRST) begin
            bemf_state = PH_DETECTED;
            if (slope_pos) comm_to_zc = tc;
            if (open_steps_left > 0) begin
               if (!slope_pos) open_steps_left--;
               commutate(slope_pos, tc);
            end else begin
               order.advance_steps = 2'd2;
               order.freewheel     = 1'b1;
               run_stage           = ST_MEASURE;
               blank_for(MEASURE_BLANK_US);
            end
         end else if (run_stage == ST_MEASURE) begin
            if (open_steps_left == 0) begin
               wide = comm_mean;
               load_with_split(clip(wide << 4));
               open_steps_left     = 8'd1;
               order.advance_steps = 2'd2;
               order.freewheel     = 1'b1;
               blank_for(comm_mean >> 1);
            end else begin
               zc_period      = tc;
               zc_period_mean = tc;
               comm_mean      = tc >> 1;
               load_with_split(floor_sub(comm_mean >> 1, MEASURE_LEAD_US));
               comm_half       = comm_mean;
               comm_to_zc      = comm_mean >> 1;
               comm_to_zc_mean = comm_to_zc;
               run_stage       = ST_CLOSED;
               bemf_state      = PH_DETECTED;
            end
         end else begin
            comm_to_zc = tc;
            zc_period  = tz;
            bemf_state = PH_DETECTED;
         end
      endfunction

      function void note_event(sbct_item_type ev);
         order = '0;
         if (motor_halted) begin
            order.freewheel = 1'b1;
         end else begin
            case (ev.cmd)
               CMD_ZERO_CROSS:
                  take_crossing(ev.slope_positive, ev.comm_timer_us, ev.zcd_timer_us);
               CMD_TIMER:
                  if (split_pending) begin
                     order.freewheel = 1'b1;
                     split_pending   = 1'b0;
                     load_now(split_us);
                  end else begin
                     commutate(ev.slope_positive, ev.comm_timer_us);
                  end
               CMD_WATCHDOG: begin
                  motor_halted    = 1'b1;
                  order.freewheel = 1'b1;
               end
               default: ;
            endcase
         end
         order.pwm_on_us = pwm_on;
         order.stage     = run_stage;
         order.stopped   = motor_halted;
         orders_due.push_back(order);
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         mismatches++;
         $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
      endtask

      task check_field(string name, longint unsigned got, longint unsigned want);
         if (got != want) report(name, got, want);
      endtask

      task check_orders(sbct_result_type seen);
         sbct_result_type want;
         if (orders_due.size() == 0) begin
            report("result with no event waiting", 0, 0);
            return;
         end
         want = orders_due.pop_front();
         check_field("timer_load", seen.timer_load, want.timer_load);
         check_field("timer_delay_us", seen.timer_delay_us, want.timer_delay_us);
         check_field("advance_steps", seen.advance_steps, want.advance_steps);
         check_field("freewheel", seen.freewheel, want.freewheel);
         check_field("blanking_start", seen.blanking_start, want.blanking_start);
         check_field("blanking_us", seen.blanking_us, want.blanking_us);
         check_field("pwm_on_us", seen.pwm_on_us, want.pwm_on_us);
         check_field("stage", seen.stage, want.stage);
         check_field("zcd_lost", seen.zcd_lost, want.zcd_lost);
         check_field("stopped", seen.stopped, want.stopped);
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_cmd = CMD_ZERO_CROSS;
   logic                   req_slope_positive = 1'b0;
   logic [PORT_TIME_W-1:0] req_comm_timer_us = '0;
   logic [PORT_TIME_W-1:0] req_zcd_timer_us = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_timer_load;
   logic [PORT_TIME_W-1:0] rsp_timer_delay_us;
   logic [1:0]             rsp_advance_steps;
   logic                   rsp_freewheel;
   logic                   rsp_blanking_start;
   logic [PORT_TIME_W-1:0] rsp_blanking_us;
   logic [7:0]             rsp_pwm_on_us;
   logic [1:0]             rsp_stage;
   logic                   rsp_zcd_lost;
   logic                   rsp_stopped;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_STARTUP_STEPS;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   commutation_tracker sb;
   int send_idle_pct = 10;
   int stall_pct = 62;
   int quiet_cycles = 0;

   sensorless_bldc_commutation_timing dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      sbct_result_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.timer_load     = rsp_timer_load;
         seen.timer_delay_us = rsp_timer_delay_us;
         seen.advance_steps  = rsp_advance_steps;
         seen.freewheel      = rsp_freewheel;
         seen.blanking_start = rsp_blanking_start;
         seen.blanking_us    = rsp_blanking_us;
         seen.pwm_on_us      = rsp_pwm_on_us;
         seen.stage          = rsp_stage;
         seen.zcd_lost       = rsp_zcd_lost;
         seen.stopped        = rsp_stopped;
         sb.check_orders(seen);
      end
   end

   // Ends the run when neither channel completes a transfer for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic logic [PORT_TIME_W-1:0] pick_time();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 4) return '0;
      if (roll < 8) return '1;
      if (roll < 18) return PORT_TIME_W'($urandom);
      return PORT_TIME_W'($urandom_range(30000, 20));
   endfunction

   function automatic sbct_item_type make_event(logic [1:0] cmd, logic slope,
                                                logic [PORT_TIME_W-1:0] tc,
                                                logic [PORT_TIME_W-1:0] tz);
      sbct_item_type ev;
      ev.cmd            = cmd;
      ev.slope_positive = slope;
      ev.comm_timer_us  = tc;
      ev.zcd_timer_us   = tz;
      return ev;
   endfunction

   // Mostly follows a running motor: rising step, crossing, falling step, with discharge
   // reloads in between; the rest is noise. Never halts the block.
   function automatic sbct_item_type next_event();
      sbct_item_type ev;
      ev = make_event(CMD_ZERO_CROSS, 1'($urandom_range(1)), pick_time(), pick_time());
      if ($urandom_range(99) < 10) begin
         case ($urandom_range(2))
            0:       ev.cmd = CMD_ZERO_CROSS;
            1:       ev.cmd = CMD_TIMER;
            default: ev.cmd = CMD_UNUSED;
         endcase
      end else if (sb.run_stage == ST_FIRST) begin
         ev.cmd = ($urandom_range(99) < 70) ? CMD_ZERO_CROSS : CMD_TIMER;
      end else if (sb.run_stage == ST_MEASURE) begin
         ev.cmd = ($urandom_range(99) < 90) ? CMD_ZERO_CROSS : CMD_TIMER;
      end else if (sb.split_pending) begin
         ev.cmd = CMD_TIMER;
      end else if (sb.bemf_state == PH_COMMUTATE) begin
         ev.cmd            = CMD_TIMER;
         ev.slope_positive = 1'b0;
      end else if (sb.bemf_state == PH_WAITING) begin
         ev.cmd            = ($urandom_range(99) < 90) ? CMD_ZERO_CROSS : CMD_TIMER;
         ev.slope_positive = 1'b1;
      end else begin
         ev.cmd            = ($urandom_range(99) < 85) ? CMD_TIMER : CMD_ZERO_CROSS;
         ev.slope_positive = 1'b1;
      end
      if (ev.cmd == CMD_TIMER && !ev.slope_positive && sb.run_stage == ST_CLOSED &&
          !sb.split_pending && sb.bemf_state != PH_COMMUTATE)
         ev.slope_positive = 1'b1;
      return ev;
   endfunction

   task automatic send_event(input sbct_item_type ev);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_cmd            <= ev.cmd;
      req_slope_positive <= ev.slope_positive;
      req_comm_timer_us  <= ev.comm_timer_us;
      req_zcd_timer_us   <= ev.zcd_timer_us;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_event(ev);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic configure(input int seg);
      logic [CSR_DATA_W-1:0] steps, init_comm, pwm_init, pwm_limit, dis_limit, ramp;
      req_valid <= 1'b0;
      while (sb.orders_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      case (seg)
         0: begin
            steps = 255; init_comm = '1; pwm_init = 0;
            pwm_limit = 255; dis_limit = 0; ramp = 0;
         end
         1: begin
            steps = 0; init_comm = 0; pwm_init = 255;
            pwm_limit = 0; dis_limit = 255; ramp = 255;
         end
         default: begin
            steps     = CSR_DATA_W'($urandom_range(255));
            init_comm = pick_time();
            pwm_init  = CSR_DATA_W'($urandom_range(255));
            pwm_limit = CSR_DATA_W'($urandom_range(255));
            dis_limit = CSR_DATA_W'($urandom_range(255));
            ramp      = CSR_DATA_W'($urandom_range(4));
         end
      endcase
      write_reg(CSR_STARTUP_STEPS, steps);
      write_reg(CSR_INIT_COMM_AVG, init_comm);
      write_reg(CSR_PWM_ON_INIT, pwm_init);
      write_reg(CSR_PWM_ON_LIMIT, pwm_limit);
      write_reg(CSR_DISCHARGE_LIM, dis_limit);
      write_reg(CSR_RAMP_PERIOD, ramp);
      csr_we <= 1'b0;
   endtask

   initial begin
      sbct_item_type ev;
      bit            trip_on_sequence;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Start at the on-time limit so that a lost crossing grows the discharge time.
      write_reg(CSR_PWM_ON_INIT, CSR_DATA_W'(PWM_ON_LIMIT_RST));
      csr_we <= 1'b0;
      send_event(make_event(CMD_UNUSED, 1'b1, '1, '1));
      send_event(make_event(CMD_TIMER, 1'b0, '1, '0));
      send_event(make_event(CMD_TIMER, 1'b1, 24'd1234, 24'd5678));
      send_event(make_event(CMD_ZERO_CROSS, 1'b1, '0, '1));
      repeat (6) send_event(make_event(CMD_ZERO_CROSS, 1'b0, 24'd4000, 24'd4100));
      send_event(make_event(CMD_ZERO_CROSS, 1'b0, 24'd4000, 24'd4000));
      send_event(make_event(CMD_TIMER, 1'b0, 24'd3000, 24'd3000));
      send_event(make_event(CMD_ZERO_CROSS, 1'b1, 24'd9000, 24'd9000));
      send_event(make_event(CMD_ZERO_CROSS, 1'b1, 24'd8000, 24'd8000));
      send_event(make_event(CMD_TIMER, 1'b1, 24'd2000, 24'd2000));
      send_event(make_event(CMD_TIMER, 1'b0, 24'd2000, 24'd2000));
      send_event(make_event(CMD_ZERO_CROSS, 1'b1, 24'd2000, 24'd4000));
      send_event(make_event(CMD_TIMER, 1'b1, 24'd2100, 24'd2100));
      send_event(make_event(CMD_TIMER, 1'b0, 24'd2100, 24'd2100));
      // No crossing between the steps: lost, back to freewheel measurement.
      send_event(make_event(CMD_TIMER, 1'b1, 24'd2100, 24'd2100));
      send_event(make_event(CMD_ZERO_CROSS, 1'b1, 24'd7000, 24'd7000));
      send_event(make_event(CMD_ZERO_CROSS, 1'b1, 24'd6000, 24'd6000));
      send_event(make_event(CMD_TIMER, 1'b1, 24'd1500, 24'd1500));
      send_event(make_event(CMD_TIMER, 1'b0, 24'd1500, 24'd1500));
      send_event(make_event(CMD_TIMER, 1'b0, 24'd1500, 24'd1500));

      for (int seg = 0; seg < 5; seg++) begin
         send_idle_pct = (seg < 2) ? 10 : ((seg < 4) ? 62 : 0);
         stall_pct     = (seg < 2) ? 62 : ((seg < 4) ? 10 : 0);
         configure(seg);
         repeat (150) send_event(next_event());
      end

      // The motor is stopped either by a slipped sequence or by the watchdog, then
      // every further event must be ignored.
      trip_on_sequence = 1'($urandom_range(1));
      for (int n = 0; n < 10; n++) begin
         ev = make_event(CMD_WATCHDOG, 1'($urandom_range(1)), pick_time(), pick_time());
         if (sb.motor_halted) begin
            ev.cmd = 2'($urandom_range(3));
         end else if (trip_on_sequence) begin
            if (sb.split_pending) begin
               ev.cmd            = CMD_TIMER;
               ev.slope_positive = 1'b1;
            end else if (sb.run_stage != ST_CLOSED || sb.bemf_state == PH_COMMUTATE) begin
               ev.cmd = CMD_ZERO_CROSS;
            end else begin
               ev.cmd            = CMD_TIMER;
               ev.slope_positive = 1'b0;
            end
         end
         send_event(ev);
      end

      req_valid <= 1'b0;
      while (sb.orders_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
